// ----- hdl/triggered_capture_scope_core_assert.svh -----
// Assertion macros shared by the capture scope RTL.
// The macros expect signals named clk and rst_n in the using module.
`ifndef TRIGGERED_CAPTURE_SCOPE_CORE_ASSERT_SVH
`define TRIGGERED_CAPTURE_SCOPE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcs assertion failed");

// Next-cycle implication, checked outside reset.
`define TCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcs assertion failed");

`endif

// ----- hdl/tcs_pkg.sv -----
// Package for the triggered capture scope: widths, codes, masks and shared types.
// Used by every module of the block; depends on nothing.
package tcs_pkg;

    localparam int LANES = 8;
    localparam int LANE_W = $clog2(LANES);
    localparam int WORD_W = 16;
    localparam int ADDR_W = 12;
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] LANE_LIMIT = CNT_W'(LANES);
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic CMD_START = 1'b1;

    localparam logic [4:0] TRIG_ARM_BITS  = 5'h18;
    localparam logic [4:0] TRIG_KEEP_LOW  = 5'h0f;
    localparam logic [4:0] TRIG_KEEP_HIGH = 5'h17;
    localparam logic [4:0] TRIG_CLR_ABOVE = 5'h05;
    localparam logic [4:0] TRIG_CLR_BELOW = 5'h03;
    localparam logic [4:0] TRIG_CLR_EQUAL = 5'h06;

    typedef enum logic [2:0] {
        REG_TIME_SCALE,
        REG_TRIGGER_LEVEL,
        REG_TRIGGER_LANE,
        REG_CHANNEL_COUNT,
        REG_BUFFER_LAST,
        REG_TRIGGER_CONDITION,
        REG_PRETRIGGER_FRAMES,
        REG_POSTTRIGGER_FRAMES
    } reg_idx_t;

    typedef enum logic [1:0] {
        PHASE_PRE,
        PHASE_ARM,
        PHASE_POST
    } phase_t;

    typedef struct packed {
        logic [15:0]       time_scale;
        logic [15:0]       trigger_level;
        logic [2:0]        trigger_lane;
        logic [CNT_W-1:0]  channel_count;
        logic [ADDR_W-1:0] buffer_last;
        logic [4:0]        trigger_condition;
        logic [15:0]       pretrigger_frames;
        logic [15:0]       posttrigger_frames;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0]            base;
        logic [LANE_W-1:0]            last_idx;
        phase_t                       phase;
        logic [LANES-1:0][WORD_W-1:0] words;
    } frame_t;

endpackage

// ----- hdl/tcs_cfg.sv -----
// Configuration register file of the capture scope behind an APB-style port.
// Depends on tcs_pkg for the register map and the cfg_t bundle.
module tcs_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcs_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcs_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcs_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output tcs_pkg::cfg_t                cfg
);

    tcs_pkg::cfg_t    cfg_reg;
    tcs_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = tcs_pkg::reg_idx_t'(paddr[tcs_pkg::PADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_scale         <= '0;
            cfg_reg.trigger_level      <= '0;
            cfg_reg.trigger_lane       <= '0;
            cfg_reg.channel_count      <= tcs_pkg::CNT_W'(1);
            cfg_reg.buffer_last        <= '1;
            cfg_reg.trigger_condition  <= '0;
            cfg_reg.pretrigger_frames  <= '0;
            cfg_reg.posttrigger_frames <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                tcs_pkg::REG_TIME_SCALE:         cfg_reg.time_scale <= pwdata[15:0];
                tcs_pkg::REG_TRIGGER_LEVEL:      cfg_reg.trigger_level <= pwdata[15:0];
                tcs_pkg::REG_TRIGGER_LANE:       cfg_reg.trigger_lane <= pwdata[2:0];
                tcs_pkg::REG_CHANNEL_COUNT:      cfg_reg.channel_count <= pwdata[3:0];
                tcs_pkg::REG_BUFFER_LAST:        cfg_reg.buffer_last <= pwdata[11:0];
                tcs_pkg::REG_TRIGGER_CONDITION:  cfg_reg.trigger_condition <= pwdata[4:0];
                tcs_pkg::REG_PRETRIGGER_FRAMES:  cfg_reg.pretrigger_frames <= pwdata[15:0];
                tcs_pkg::REG_POSTTRIGGER_FRAMES: cfg_reg.posttrigger_frames <= pwdata[15:0];
                default:                         cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            tcs_pkg::REG_TIME_SCALE:         prdata = {16'd0, cfg_reg.time_scale};
            tcs_pkg::REG_TRIGGER_LEVEL:      prdata = {16'd0, cfg_reg.trigger_level};
            tcs_pkg::REG_TRIGGER_LANE:       prdata = {29'd0, cfg_reg.trigger_lane};
            tcs_pkg::REG_CHANNEL_COUNT:      prdata = {28'd0, cfg_reg.channel_count};
            tcs_pkg::REG_BUFFER_LAST:        prdata = {20'd0, cfg_reg.buffer_last};
            tcs_pkg::REG_TRIGGER_CONDITION:  prdata = {27'd0, cfg_reg.trigger_condition};
            tcs_pkg::REG_PRETRIGGER_FRAMES:  prdata = {16'd0, cfg_reg.pretrigger_frames};
            tcs_pkg::REG_POSTTRIGGER_FRAMES: prdata = {16'd0, cfg_reg.posttrigger_frames};
            default:                         prdata = '0;
        endcase
    end

endmodule

// ----- hdl/tcs_front.sv -----
// Front end of the capture scope: capture sequencing, decimation, trigger and ring pointer.
// Turns each accepted request into at most one frame descriptor; depends on tcs_pkg.
module tcs_front
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  tcs_pkg::cfg_t                                 cfg,
    input  logic                                          take,
    input  logic                                          cmd,
    input  logic [tcs_pkg::LANES-1:0][tcs_pkg::WORD_W-1:0] words,
    output logic                                          frame_push,
    output tcs_pkg::frame_t                               frame
);

    logic [tcs_pkg::ADDR_W-1:0] ptr_reg, ptr_next;
    logic [15:0]                div_reg, div_next;
    logic [15:0]                pre_reg, pre_next;
    logic [15:0]                post_reg, post_next;
    logic [4:0]                 status_reg, status_next;

    logic [tcs_pkg::WORD_W-1:0] lane_val;
    logic signed [16:0]         diff;
    logic                       d_pos;
    logic                       d_neg;
    logic [4:0]                 trig_new;
    logic [tcs_pkg::CNT_W-1:0]  n_words;
    logic [tcs_pkg::ADDR_W:0]   ptr_sum;
    logic [tcs_pkg::ADDR_W-1:0] ptr_wrap;
    logic                       fire;
    tcs_pkg::phase_t            phase;

    assign lane_val = words[cfg.trigger_lane];
    assign diff     = signed'({lane_val[15], lane_val})
                    - signed'({cfg.trigger_level[15], cfg.trigger_level});
    assign d_neg    = diff[16];
    assign d_pos    = !diff[16] && (diff != 17'sd0);

    always_comb
    begin
        trig_new = status_reg;
        if ((status_reg & tcs_pkg::TRIG_ARM_BITS) != 5'd0)
        begin
            if (d_pos)
            begin
                trig_new = status_reg & tcs_pkg::TRIG_KEEP_LOW;
            end
            if (d_neg)
            begin
                trig_new = status_reg & tcs_pkg::TRIG_KEEP_HIGH;
            end
        end
        else if (d_pos)
        begin
            trig_new = status_reg & tcs_pkg::TRIG_CLR_ABOVE;
        end
        else if (d_neg)
        begin
            trig_new = status_reg & tcs_pkg::TRIG_CLR_BELOW;
        end
        else
        begin
            trig_new = status_reg & tcs_pkg::TRIG_CLR_EQUAL;
        end
    end

    assign n_words  = (cfg.channel_count > tcs_pkg::LANE_LIMIT) ? tcs_pkg::LANE_LIMIT
                                                                : cfg.channel_count;
    assign ptr_sum  = {1'b0, ptr_reg} + {{(tcs_pkg::ADDR_W + 1 - tcs_pkg::CNT_W){1'b0}}, n_words};
    assign ptr_wrap = (ptr_sum > {1'b0, cfg.buffer_last}) ? '0
                                                          : ptr_sum[tcs_pkg::ADDR_W-1:0];

    always_comb
    begin
        ptr_next    = ptr_reg;
        div_next    = div_reg;
        pre_next    = pre_reg;
        post_next   = post_reg;
        status_next = status_reg;
        fire        = 1'b0;
        phase       = tcs_pkg::PHASE_PRE;
        frame_push  = 1'b0;
        if (take)
        begin
            if (cmd == tcs_pkg::CMD_START)
            begin
                pre_next    = cfg.pretrigger_frames;
                post_next   = cfg.posttrigger_frames;
                status_next = cfg.trigger_condition;
                div_next    = '0;
            end
            else if (post_reg != 16'd0)
            begin
                fire     = (div_reg == 16'd0);
                div_next = fire ? cfg.time_scale : div_reg - 16'd1;
                priority if (pre_reg != 16'd0)
                begin
                    phase = tcs_pkg::PHASE_PRE;
                    if (fire)
                    begin
                        pre_next = pre_reg - 16'd1;
                    end
                end
                else if (status_reg != 5'd0)
                begin
                    phase       = tcs_pkg::PHASE_ARM;
                    status_next = trig_new;
                end
                else
                begin
                    phase = tcs_pkg::PHASE_POST;
                    if (fire)
                    begin
                        post_next = post_reg - 16'd1;
                    end
                end
                if (fire)
                begin
                    ptr_next   = ptr_wrap;
                    frame_push = (n_words != '0);
                end
            end
        end
    end

    always_comb
    begin
        frame.base     = ptr_reg;
        frame.last_idx = tcs_pkg::LANE_W'(n_words - tcs_pkg::CNT_W'(1));
        frame.phase    = phase;
        frame.words    = words;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            div_reg    <= '0;
            pre_reg    <= '0;
            post_reg   <= '0;
            status_reg <= '0;
        end
        else
        begin
            ptr_reg    <= ptr_next;
            div_reg    <= div_next;
            pre_reg    <= pre_next;
            post_reg   <= post_next;
            status_reg <= status_next;
        end
    end

endmodule

// ----- hdl/tcs_fifo.sv -----
// Two-entry frame queue between the front end and the write sequencer.
// Holds tcs_pkg::frame_t descriptors; depends on tcs_pkg.
module tcs_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tcs_pkg::frame_t din,
    input  logic            pop,
    output tcs_pkg::frame_t dout,
    output logic            valid,
    output logic            full
);

    tcs_pkg::frame_t mem [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign dout  = mem[rd_ptr_reg];
    assign valid = (count_reg != 2'd0);
    assign full  = (count_reg == 2'd2);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- hdl/tcs_back.sv -----
// Write sequencer of the capture scope: emits one memory write request per cycle while pop is held.
// Takes frames from tcs_fifo into an output register; depends on tcs_pkg and the assert macros.
`include "triggered_capture_scope_core_assert.svh"

module tcs_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fifo_valid,
    input  tcs_pkg::frame_t             fifo_dout,
    output logic                        fifo_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [tcs_pkg::ADDR_W-1:0]  write_addr,
    output logic [tcs_pkg::WORD_W-1:0]  write_data,
    output logic                        last,
    output logic [1:0]                  phase
);

    tcs_pkg::frame_t            frame_reg;
    logic                       busy_reg;
    logic [tcs_pkg::LANE_W-1:0] k_reg;
    logic                       out_valid_reg;
    logic [tcs_pkg::ADDR_W-1:0] addr_reg;
    logic [tcs_pkg::WORD_W-1:0] data_reg;
    logic                       last_reg;
    tcs_pkg::phase_t            phase_reg;

    logic emit;
    logic done;
    logic take;

    assign emit     = busy_reg && (!out_valid_reg || pop);
    assign done     = emit && (k_reg == frame_reg.last_idx);
    assign take     = fifo_valid && (!busy_reg || done);
    assign fifo_pop = take;

    assign empty      = !out_valid_reg;
    assign write_addr = addr_reg;
    assign write_data = data_reg;
    assign last       = last_reg;
    assign phase      = phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
                k_reg    <= '0;
            end
            else if (emit)
            begin
                k_reg <= k_reg + tcs_pkg::LANE_W'(1);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            frame_reg <= fifo_dout;
        end
        if (emit)
        begin
            addr_reg  <= frame_reg.base
                       + {{(tcs_pkg::ADDR_W - tcs_pkg::LANE_W){1'b0}}, k_reg};
            data_reg  <= frame_reg.words[k_reg];
            last_reg  <= (k_reg == frame_reg.last_idx);
            phase_reg <= frame_reg.phase;
        end
    end

    `TCS_ASSERT_NEXT(a_busy_kept, busy_reg && !emit, busy_reg)
    `TCS_ASSERT_NEXT(a_done_idle, done && !take, !busy_reg)
    `TCS_ASSERT_IMPLY(a_index_in_frame, busy_reg, k_reg <= frame_reg.last_idx)
    `TCS_ASSERT_IMPLY(a_phase_code, out_valid_reg, phase_reg != 2'd3)

endmodule

// ----- hdl/triggered_capture_scope_core.sv -----
// Channel  | Handshake                          | Payload
// input    | push / full                        | cmd, word0 .. word7
// result   | pop / empty                        | write_addr, write_data, last, phase
// config   | psel, penable, pwrite / pready     | paddr, pwdata, prdata
//
// A tick is classified in the cycle it is accepted; a recorded frame of n words
// then leaves as n write requests from the write sequencer, one per cycle while pop
// is held. The two-entry frame queue lets new ticks enter while earlier frames
// are still being written; full rises only when it is full.
// rst_n clears all sequencing state and restores register defaults; no clearing pass.
// Top level of the triggered capture scope; depends on tcs_pkg and all tcs_* modules.
module triggered_capture_scope_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         cmd,
    input  logic [15:0]                  word0,
    input  logic [15:0]                  word1,
    input  logic [15:0]                  word2,
    input  logic [15:0]                  word3,
    input  logic [15:0]                  word4,
    input  logic [15:0]                  word5,
    input  logic [15:0]                  word6,
    input  logic [15:0]                  word7,
    output logic                         empty,
    input  logic                         pop,
    output logic [11:0]                  write_addr,
    output logic [15:0]                  write_data,
    output logic                         last,
    output logic [1:0]                   phase,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcs_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcs_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcs_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    tcs_pkg::cfg_t                                 cfg;
    tcs_pkg::frame_t                               frame;
    tcs_pkg::frame_t                               fifo_dout;
    logic [tcs_pkg::LANES-1:0][tcs_pkg::WORD_W-1:0] words;
    logic                                          take;
    logic                                          frame_push;
    logic                                          fifo_valid;
    logic                                          fifo_pop;

    assign words = {word7, word6, word5, word4, word3, word2, word1, word0};
    assign take  = push && !full;

    tcs_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .take       (take),
        .cmd        (cmd),
        .words      (words),
        .frame_push (frame_push),
        .frame      (frame)
    );

    tcs_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (frame_push),
        .din   (frame),
        .pop   (fifo_pop),
        .dout  (fifo_dout),
        .valid (fifo_valid),
        .full  (full)
    );

    tcs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_valid (fifo_valid),
        .fifo_dout  (fifo_dout),
        .fifo_pop   (fifo_pop),
        .pop        (pop),
        .empty      (empty),
        .write_addr (write_addr),
        .write_data (write_data),
        .last       (last),
        .phase      (phase)
    );

endmodule

// ----- dv/triggered_capture_scope_checker.sv -----
// Checker for the triggered capture scope core: it watches the input, result and
// register channels, predicts every capture memory write and compares them in order.
// Depends on tcs_pkg for the register indexes, phase codes and trigger masks.
`timescale 1ns / 100ps

module triggered_capture_scope_checker
    import tcs_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic                         full,
    input  logic                         cmd,
    input  logic [7:0][15:0]             lanes,
    input  logic                         empty,
    input  logic                         pop,
    input  logic [11:0]                  write_addr,
    input  logic [15:0]                  write_data,
    input  logic                         last,
    input  logic [1:0]                   phase,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [PADDR_W-1:0]           paddr,
    input  logic [PDATA_W-1:0]           pwdata,
    output int                           fail_count,
    output int                           pending
);

    localparam int RING_DEPTH = 1 << ADDR_W;

    typedef struct packed {
        logic [11:0] addr;
        logic [15:0] data;
        logic        last;
        phase_t      phase;
    } mem_write_t;

    mem_write_t  write_q[$];
    cfg_t        cfg;
    logic [11:0] ring_ptr;
    logic [15:0] divider;
    logic [15:0] pre_left;
    logic [15:0] post_left;
    logic [4:0]  trig_state;

    function automatic bit divider_tick();
        if (divider != 0) begin
            divider = divider - 1'b1;
            return 1'b0;
        end
        divider = cfg.time_scale;
        return 1'b1;
    endfunction

    task automatic record_frame(input logic [7:0][15:0] w, input phase_t ph);
        int n;
        int p;
        int k;
        mem_write_t e;
        n = int'(cfg.channel_count);
        if (n > LANES)
            n = LANES;
        p = int'(ring_ptr);
        for (k = 0; k < n; k++)
        begin
            e.addr  = 12'((p + k) % RING_DEPTH);
            e.data  = w[k];
            e.last  = (k == n - 1);
            e.phase = ph;
            write_q.push_back(e);
        end
        p += n;
        ring_ptr = (p > int'(cfg.buffer_last)) ? 12'd0 : 12'(p % RING_DEPTH);
    endtask

    task automatic trigger_update(input logic [7:0][15:0] w);
        int d;
        d = int'($signed(w[cfg.trigger_lane])) - int'($signed(cfg.trigger_level));
        if ((trig_state & TRIG_ARM_BITS) != 0)
        begin
            if (d > 0)
                trig_state &= TRIG_KEEP_LOW;
            if (d < 0)
                trig_state &= TRIG_KEEP_HIGH;
        end
        else
        begin
            if (d > 0)
                trig_state &= TRIG_CLR_ABOVE;
            if (d < 0)
                trig_state &= TRIG_CLR_BELOW;
            if (d == 0)
                trig_state &= TRIG_CLR_EQUAL;
        end
    endtask

    task automatic predict_request(input logic c, input logic [7:0][15:0] w);
        if (c == CMD_START)
        begin
            pre_left   = cfg.pretrigger_frames;
            post_left  = cfg.posttrigger_frames;
            trig_state = cfg.trigger_condition;
            divider    = '0;
            return;
        end
        if (post_left == 0)
            return;
        if (pre_left != 0)
        begin
            if (divider_tick())
            begin
                pre_left = pre_left - 1'b1;
                record_frame(w, PHASE_PRE);
            end
            return;
        end
        if (trig_state != 0)
        begin
            trigger_update(w);
            if (divider_tick())
                record_frame(w, PHASE_ARM);
            return;
        end
        if (divider_tick())
        begin
            post_left = post_left - 1'b1;
            record_frame(w, PHASE_POST);
        end
    endtask

    task automatic flag_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mem_write_t want;
        if (!rst_n)
        begin
            cfg = '{time_scale: '0, trigger_level: '0, trigger_lane: '0,
                    channel_count: 4'd1, buffer_last: 12'hFFF, trigger_condition: '0,
                    pretrigger_frames: '0, posttrigger_frames: '0};
            ring_ptr   = '0;
            divider    = '0;
            pre_left   = '0;
            post_left  = '0;
            trig_state = '0;
            write_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (write_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: write request with none expected, addr 0x%0h data 0x%0h",
                             $time, write_addr, write_data);
                end
                else
                begin
                    want = write_q.pop_front();
                    if (write_addr !== want.addr)
                        flag_mismatch("write_addr", 16'(want.addr), 16'(write_addr));
                    if (write_data !== want.data)
                        flag_mismatch("write_data", want.data, write_data);
                    if (last !== want.last)
                        flag_mismatch("last", 16'(want.last), 16'(last));
                    if (phase !== want.phase)
                        flag_mismatch("phase", 16'(want.phase), 16'(phase));
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_TIME_SCALE:         cfg.time_scale         = pwdata[15:0];
                    REG_TRIGGER_LEVEL:      cfg.trigger_level      = pwdata[15:0];
                    REG_TRIGGER_LANE:       cfg.trigger_lane       = pwdata[2:0];
                    REG_CHANNEL_COUNT:      cfg.channel_count      = pwdata[CNT_W-1:0];
                    REG_BUFFER_LAST:        cfg.buffer_last        = pwdata[ADDR_W-1:0];
                    REG_TRIGGER_CONDITION:  cfg.trigger_condition  = pwdata[4:0];
                    REG_PRETRIGGER_FRAMES:  cfg.pretrigger_frames  = pwdata[15:0];
                    REG_POSTTRIGGER_FRAMES: cfg.posttrigger_frames = pwdata[15:0];
                    default: ;
                endcase
            end
            if (push && !full)
                predict_request(cmd, lanes);
        end
        pending = write_q.size();
    end

endmodule

// ----- dv/tb_triggered_capture_scope_core.sv -----
// Testbench top for the triggered capture scope core: it drives directed and random
// capture sequences and register settings, and gives the verdict.
// Depends on tcs_pkg, triggered_capture_scope_core and triggered_capture_scope_checker.
`timescale 1ns / 100ps

module tb_triggered_capture_scope_core;
    import tcs_pkg::*;

    localparam logic CMD_TICK       = ~CMD_START;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   DRAIN_CYCLES   = 20;
    localparam int   FILL_TICKS     = 6;
    localparam int   RANDOM_PHASES  = 6;
    localparam int   PHASE_TICKS    = 12;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic                 cmd;
    logic [7:0][15:0]     lanes;
    logic                 empty;
    logic                 pop;
    logic [11:0]          write_addr;
    logic [15:0]          write_data;
    logic                 last;
    logic [1:0]           phase;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    int                   fail_count;
    int                   pending;
    int                   quiet_cycles;
    bit                   calm;
    logic [15:0]          level_set;
    logic [2:0]           lane_set;

    always #10 clk = ~clk;

    triggered_capture_scope_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .word0      (lanes[0]),
        .word1      (lanes[1]),
        .word2      (lanes[2]),
        .word3      (lanes[3]),
        .word4      (lanes[4]),
        .word5      (lanes[5]),
        .word6      (lanes[6]),
        .word7      (lanes[7]),
        .empty      (empty),
        .pop        (pop),
        .write_addr (write_addr),
        .write_data (write_data),
        .last       (last),
        .phase      (phase),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    triggered_capture_scope_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .lanes      (lanes),
        .empty      (empty),
        .pop        (pop),
        .write_addr (write_addr),
        .write_data (write_data),
        .last       (last),
        .phase      (phase),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        int stall;
        stall = 0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall = $urandom_range(1, 12) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (psel && penable && pready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_TRIGGER_LEVEL)
            level_set = value[15:0];
        if (idx == REG_TRIGGER_LANE)
            lane_set = value[2:0];
    endtask

    task automatic load_settings(input cfg_t s);
        write_reg(REG_TIME_SCALE,         32'(s.time_scale));
        write_reg(REG_TRIGGER_LEVEL,      32'(s.trigger_level));
        write_reg(REG_TRIGGER_LANE,       32'(s.trigger_lane));
        write_reg(REG_CHANNEL_COUNT,      32'(s.channel_count));
        write_reg(REG_BUFFER_LAST,        32'(s.buffer_last));
        write_reg(REG_TRIGGER_CONDITION,  32'(s.trigger_condition));
        write_reg(REG_PRETRIGGER_FRAMES,  32'(s.pretrigger_frames));
        write_reg(REG_POSTTRIGGER_FRAMES, 32'(s.posttrigger_frames));
    endtask

    task automatic send_request(input logic c, input logic [7:0][15:0] w);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        push  <= 1'b1;
        cmd   <= c;
        lanes <= w;
        do @(posedge clk); while (full);
    endtask

    // The sender holds off until every predicted write has been taken.
    task automatic settle();
        push <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The trigger lane is steered near the level so that the trigger can arm and fire.
    function automatic logic [7:0][15:0] sample_words();
        logic [7:0][15:0] w;
        w = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 4))
            0: w[lane_set] = level_set;
            1: w[lane_set] = level_set + 16'd1;
            2: w[lane_set] = level_set - 16'd1;
            3: w[lane_set] = level_set + 16'($urandom_range(0, 400)) - 16'd200;
            default: ;
        endcase
        return w;
    endfunction

    initial
    begin
        cfg_t             s;
        logic [15:0]      trig_seq [5];
        logic [7:0][15:0] w;
        int               p;
        int               i;

        trig_seq = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
        rst_n = 1'b0;
        push = 1'b0;
        cmd = CMD_TICK;
        lanes = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        quiet_cycles = 0;
        level_set = '0;
        lane_set = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // With the reset settings no capture runs, started or not.
        send_request(CMD_TICK, '1);
        send_request(CMD_START, '1);
        send_request(CMD_TICK, '0);
        settle();

        // No trigger condition: pre-trigger frames lead straight into post-trigger frames.
        s = '{time_scale: 16'd0, trigger_level: 16'h8000, trigger_lane: 3'd7,
              channel_count: 4'd8, buffer_last: 12'hFFF, trigger_condition: 5'd0,
              pretrigger_frames: 16'd2, posttrigger_frames: 16'd2};
        load_settings(s);
        send_request(CMD_START, '0);
        send_request(CMD_TICK, '1);
        send_request(CMD_TICK, '0);
        send_request(CMD_TICK, 128'h8001_4002_2004_1008_0810_0420_0240_0180);
        send_request(CMD_TICK, 128'h7FFE_BFFD_DFFB_EFF7_F7EF_FBDF_FDBF_FE7F);
        send_request(CMD_TICK, '1);
        settle();

        // Full trigger condition on lane 0: arm below and above, then fire on all three.
        // The channel count saturates and the small ring wraps on every frame.
        s = '{time_scale: 16'd1, trigger_level: 16'h0000, trigger_lane: 3'd0,
              channel_count: 4'd15, buffer_last: 12'd5, trigger_condition: 5'h1F,
              pretrigger_frames: 16'd0, posttrigger_frames: 16'd1};
        load_settings(s);
        send_request(CMD_START, '1);
        for (i = 0; i < 5; i++)
        begin
            w = {$urandom, $urandom, $urandom, $urandom};
            w[0] = trig_seq[i];
            send_request(CMD_TICK, w);
        end
        for (i = 0; i < 3; i++)
            send_request(CMD_TICK, {$urandom, $urandom, $urandom, $urandom});
        settle();

        // Zero channel count and the widest divider: frames write nothing.
        s = '{time_scale: 16'hFFFF, trigger_level: 16'h7FFF, trigger_lane: 3'd3,
              channel_count: 4'd0, buffer_last: 12'd0, trigger_condition: 5'd0,
              pretrigger_frames: 16'hFFFF, posttrigger_frames: 16'hFFFF};
        load_settings(s);
        send_request(CMD_START, '0);
        send_request(CMD_TICK, '1);
        send_request(CMD_TICK, '1);
        settle();

        // One frame with a zero top address brings the ring pointer back to zero.
        s = '{time_scale: 16'd0, trigger_level: 16'h0000, trigger_lane: 3'd0,
              channel_count: 4'd1, buffer_last: 12'd0, trigger_condition: 5'd0,
              pretrigger_frames: 16'd0, posttrigger_frames: 16'd1};
        load_settings(s);
        send_request(CMD_START, '0);
        send_request(CMD_TICK, 128'hA5C3);
        settle();

        // Seven-word frames run back to back from address zero.
        s = '{time_scale: 16'd0, trigger_level: 16'h0000, trigger_lane: 3'd0,
              channel_count: 4'd7, buffer_last: 12'hFFF, trigger_condition: 5'd0,
              pretrigger_frames: 16'd0, posttrigger_frames: 16'hFFFF};
        load_settings(s);
        send_request(CMD_START, '0);
        for (i = 0; i < FILL_TICKS; i++)
            send_request(CMD_TICK, {$urandom, $urandom, $urandom, $urandom});
        settle();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == RANDOM_PHASES - 1)
                calm = 1'b1;
            s.time_scale = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 3));
            s.trigger_level = 16'($urandom);
            s.trigger_lane = 3'($urandom_range(0, 7));
            s.channel_count = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                          : 4'($urandom_range(1, 8));
            s.buffer_last = $urandom_range(0, 1) ? 12'hFFF : 12'($urandom_range(0, 40));
            s.trigger_condition = 5'($urandom_range(0, 31));
            s.pretrigger_frames = ($urandom_range(0, 9) == 0) ? 16'hFFFF
                                                              : 16'($urandom_range(0, 4));
            s.posttrigger_frames = ($urandom_range(0, 7) == 0) ? 16'd0
                                                               : 16'($urandom_range(1, 6));
            load_settings(s);
            if ($urandom_range(0, 3) == 0)
                send_request(CMD_TICK, sample_words());
            send_request(CMD_START, sample_words());
            for (i = 0; i < PHASE_TICKS; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_request(CMD_START, sample_words());
                else
                    send_request(CMD_TICK, sample_words());
            end
            settle();
        end

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
